FILE: rtl/core/x128p_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package x128p_pkg;

  // Murmur3 64-bit finalizer
  localparam logic [63:0] MIX_MUL_A = 64'hFF51AFD7ED558CCD;
  localparam logic [63:0] MIX_MUL_B = 64'hC4CEB9FE1A85EC53;
  localparam int unsigned MIX_SHIFT = 33;
  localparam int unsigned DRAW_31_SHIFT = 33;

  // request function codes
  localparam logic [1:0] FUNC_TOP_BITS = 2'd0;
  localparam logic [1:0] FUNC_BELOW    = 2'd1;
  localparam logic [1:0] FUNC_FULL     = 2'd2;

  // phases of one hash pass
  localparam logic [1:0] MIX_STEP_A   = 2'd0;
  localparam logic [1:0] MIX_STEP_B   = 2'd1;
  localparam logic [1:0] MIX_STEP_END = 2'd2;

  typedef enum logic [7:0] {
    ST_IDLE = 8'b0000_0001,
    ST_MIX  = 8'b0000_0010,
    ST_MUL  = 8'b0000_0100,
    ST_DRAW = 8'b0000_1000,
    ST_POW  = 8'b0001_0000,
    ST_DIV  = 8'b0010_0000,
    ST_CHK  = 8'b0100_0000,
    ST_OUT  = 8'b1000_0000
  } state_t;

endpackage

`default_nettype wire

FILE: rtl/core/xorshift128plus_random_generator_top.sv
// xorshift128+ random generator.
// Input channel (in_valid / in_stall, fields in_func, in_bit_count, in_bound)
// takes one request; the result channel (out_valid / out_stall, out_value)
// returns exactly one 64-bit zero-extended value per request, in order.
// Request steps: a draw, then the output step for top bits or full word; a
// power-of-two bound adds a multiply step, any other bound a divide and a
// rejection check per draw attempt (bit-serial restoring divider, one quotient
// bit per cycle; a rejected draw repeats the attempt, fewer than half of them on average).
// A finished result sits in the output register while the receiver stalls;
// the next request is taken meanwhile and waits for that register to free.
// cfg_wr_en with cfg_wr_data writes the seed. Reset (seed 0) and every seed
// write rerun the hash of both state words: two passes of two bit-serial
// 64-bit multiplies, with in_stall high throughout.
// rst_n is synchronous; it drops any pending result.
`timescale 1ns / 1ps
`default_nettype none

module xorshift128plus_random_generator_top (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [1:0]  in_func,
  input  wire logic [5:0]  in_bit_count,
  input  wire logic [30:0] in_bound,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [63:0]      out_value,
  input  wire logic        cfg_wr_en,
  input  wire logic [63:0] cfg_wr_data
);

  x128p_pkg::state_t state_r, state_nxt;
  logic [1:0]  step_r, step_nxt;
  logic        half_r, half_nxt;
  logic [5:0]  cnt_r, cnt_nxt;
  logic [63:0] h_r, h_nxt;
  logic [63:0] acc_r, acc_nxt;
  logic [63:0] mcand_r, mcand_nxt;
  logic [63:0] mplier_r, mplier_nxt;
  logic [63:0] st_lo_r, st_lo_nxt;
  logic [63:0] st_hi_r, st_hi_nxt;
  logic [1:0]  func_r, func_nxt;
  logic [5:0]  bits_r, bits_nxt;
  logic [30:0] bound_r, bound_nxt;
  logic [30:0] r_r, r_nxt;
  logic [30:0] div_sh_r, div_sh_nxt;
  logic [30:0] rem_r, rem_nxt;
  logic [63:0] res_r, res_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic [63:0] out_value_r, out_value_nxt;

  logic [63:0] h_x;
  logic [63:0] acc_add;
  logic [63:0] xa1, xa2, xa_new, draw_w;
  logic [5:0]  bits_sat;
  logic [6:0]  shamt;
  logic [30:0] draw_r31;
  logic        bound_pow2;
  logic [61:0] pow_prod;
  logic [31:0] div_t, div_diff;
  logic        div_ge;
  logic [31:0] chk_sum;
  logic        in_acc;
  logic        out_free;

  assign in_stall  = (state_r != x128p_pkg::ST_IDLE) || cfg_wr_en;
  assign in_acc    = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign out_value = out_value_r;
  assign out_free  = !out_valid_r || !out_stall;

  // hash xor-shift
  assign h_x = h_r ^ (h_r >> x128p_pkg::MIX_SHIFT);

  // one bit of the serial multiply
  assign acc_add = mplier_r[0] ? (acc_r + mcand_r) : acc_r;

  // xorshift128+ advance
  assign xa1    = st_lo_r ^ (st_lo_r << 23);
  assign xa2    = xa1 ^ (xa1 >> 17);
  assign xa_new = xa2 ^ st_hi_r ^ (st_hi_r >> 26);
  assign draw_w = st_hi_r + xa_new;
  assign draw_r31 = draw_w[63:x128p_pkg::DRAW_31_SHIFT];

  assign bits_sat = (bits_r > 6'd32) ? 6'd32 : bits_r;
  assign shamt    = 7'd64 - {1'b0, bits_sat};

  // zero bound also lands here and gives zero
  assign bound_pow2 = (bound_r & (bound_r - 31'd1)) == 31'd0;
  assign pow_prod   = 62'(bound_r) * 62'(r_r);

  // restoring divide step
  assign div_t    = {rem_r, div_sh_r[30]};
  assign div_ge   = div_t >= {1'b0, bound_r};
  assign div_diff = div_t - {1'b0, bound_r};

  // rejection test: r - v + bound - 1 must fit in 31 bits
  assign chk_sum = {1'b0, r_r} - {1'b0, rem_r} + {1'b0, bound_r} - 32'd1;

  always_comb begin
    state_nxt     = state_r;
    step_nxt      = step_r;
    half_nxt      = half_r;
    cnt_nxt       = cnt_r;
    h_nxt         = h_r;
    acc_nxt       = acc_r;
    mcand_nxt     = mcand_r;
    mplier_nxt    = mplier_r;
    st_lo_nxt     = st_lo_r;
    st_hi_nxt     = st_hi_r;
    func_nxt      = func_r;
    bits_nxt      = bits_r;
    bound_nxt     = bound_r;
    r_nxt         = r_r;
    div_sh_nxt    = div_sh_r;
    rem_nxt       = rem_r;
    res_nxt       = res_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_value_nxt = out_value_r;

    case (state_r)
      x128p_pkg::ST_IDLE: begin
        if (in_acc) begin
          func_nxt  = in_func;
          bits_nxt  = in_bit_count;
          bound_nxt = in_bound;
          state_nxt = x128p_pkg::ST_DRAW;
        end
      end
      x128p_pkg::ST_MIX: begin
        case (step_r)
          x128p_pkg::MIX_STEP_A: begin
            mcand_nxt  = h_x;
            acc_nxt    = '0;
            mplier_nxt = x128p_pkg::MIX_MUL_A;
            cnt_nxt    = '0;
            step_nxt   = x128p_pkg::MIX_STEP_B;
            state_nxt  = x128p_pkg::ST_MUL;
          end
          x128p_pkg::MIX_STEP_B: begin
            mcand_nxt  = h_x;
            acc_nxt    = '0;
            mplier_nxt = x128p_pkg::MIX_MUL_B;
            cnt_nxt    = '0;
            step_nxt   = x128p_pkg::MIX_STEP_END;
            state_nxt  = x128p_pkg::ST_MUL;
          end
          default: begin
            step_nxt = x128p_pkg::MIX_STEP_A;
            if (!half_r) begin
              st_lo_nxt = h_x;
              h_nxt     = ~h_x;
              half_nxt  = 1'b1;
            end else begin
              st_hi_nxt = h_x;
              state_nxt = x128p_pkg::ST_IDLE;
            end
          end
        endcase
      end
      x128p_pkg::ST_MUL: begin
        acc_nxt    = acc_add;
        mcand_nxt  = mcand_r << 1;
        mplier_nxt = mplier_r >> 1;
        cnt_nxt    = cnt_r + 6'd1;
        if (cnt_r == 6'd63) begin
          h_nxt     = acc_add;
          state_nxt = x128p_pkg::ST_MIX;
        end
      end
      x128p_pkg::ST_DRAW: begin
        st_lo_nxt = st_hi_r;
        st_hi_nxt = xa_new;
        r_nxt     = draw_r31;
        if (func_r == x128p_pkg::FUNC_TOP_BITS) begin
          res_nxt   = (bits_r == 6'd0) ? 64'd0 : (draw_w >> shamt);
          state_nxt = x128p_pkg::ST_OUT;
        end else if (func_r == x128p_pkg::FUNC_BELOW) begin
          if (bound_pow2) begin
            state_nxt = x128p_pkg::ST_POW;
          end else begin
            div_sh_nxt = draw_r31;
            rem_nxt    = '0;
            cnt_nxt    = '0;
            state_nxt  = x128p_pkg::ST_DIV;
          end
        end else begin
          // FUNC_FULL and the unused code
          res_nxt   = draw_w;
          state_nxt = x128p_pkg::ST_OUT;
        end
      end
      x128p_pkg::ST_POW: begin
        res_nxt   = {33'd0, pow_prod[61:31]};
        state_nxt = x128p_pkg::ST_OUT;
      end
      x128p_pkg::ST_DIV: begin
        rem_nxt    = div_ge ? div_diff[30:0] : div_t[30:0];
        div_sh_nxt = div_sh_r << 1;
        cnt_nxt    = cnt_r + 6'd1;
        if (cnt_r == 6'd30) begin
          state_nxt = x128p_pkg::ST_CHK;
        end
      end
      x128p_pkg::ST_CHK: begin
        if (!chk_sum[31]) begin
          res_nxt   = {33'd0, rem_r};
          state_nxt = x128p_pkg::ST_OUT;
        end else begin
          state_nxt = x128p_pkg::ST_DRAW;
        end
      end
      x128p_pkg::ST_OUT: begin
        if (out_free) begin
          out_value_nxt = res_r;
          out_valid_nxt = 1'b1;
          state_nxt     = x128p_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = x128p_pkg::ST_IDLE;
      end
    endcase

    // seed write restarts the hash of both state words
    if (cfg_wr_en) begin
      h_nxt     = cfg_wr_data;
      step_nxt  = x128p_pkg::MIX_STEP_A;
      half_nxt  = 1'b0;
      state_nxt = x128p_pkg::ST_MIX;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= x128p_pkg::ST_MIX;
      step_r      <= x128p_pkg::MIX_STEP_A;
      half_r      <= 1'b0;
      cnt_r       <= '0;
      h_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      step_r      <= step_nxt;
      half_r      <= half_nxt;
      cnt_r       <= cnt_nxt;
      h_r         <= h_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    acc_r       <= acc_nxt;
    mcand_r     <= mcand_nxt;
    mplier_r    <= mplier_nxt;
    st_lo_r     <= st_lo_nxt;
    st_hi_r     <= st_hi_nxt;
    func_r      <= func_nxt;
    bits_r      <= bits_nxt;
    bound_r     <= bound_nxt;
    r_r         <= r_nxt;
    div_sh_r    <= div_sh_nxt;
    rem_r       <= rem_nxt;
    res_r       <= res_nxt;
    out_value_r <= out_value_nxt;
  end

`ifndef SYNTHESIS
  a_accept_draws: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> state_r == x128p_pkg::ST_DRAW)
    else $error("accepted request did not start a draw");

  a_state_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == x128p_pkg::ST_IDLE |-> (st_lo_r | st_hi_r) != 64'd0)
    else $error("generator state is all zero");

  a_rem_below: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == x128p_pkg::ST_DIV |-> rem_r < bound_r)
    else $error("partial remainder not below bound");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == x128p_pkg::ST_OUT && out_valid_r && out_stall
      |=> state_r == x128p_pkg::ST_OUT)
    else $error("result left while output register was full");
`endif

endmodule

`default_nettype wire
